// ===== rtl/core/rfb_pkg.sv =====
// shared types and constants of the rotated packed frame buffer
package rfb_pkg;

   localparam int POS_W       = 10;
   localparam int COLOR_W     = 2;
   localparam int CMD_W       = 2;
   localparam int PX_W        = 11;
   localparam int ROW_W       = 10;
   localparam int COL_W       = 9;
   localparam int PROD_W      = PX_W + ROW_W;
   localparam int IDX_W       = PROD_W + 1;
   localparam int SHIFT_W     = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_ORIENTATION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRAY_MODE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH       = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT      = 2'd3;

   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   localparam logic [COLOR_W-1:0] COLOR_WHITE = 2'd3;
   localparam logic [7:0]         BYTE_WHITE  = 8'hFF;
   localparam logic [7:0]         BYTE_BLACK  = 8'h00;
   localparam logic [PX_W-1:0]    RESET_WIDTH  = 11'd800;
   localparam logic [PX_W-1:0]    RESET_HEIGHT = 11'd480;

   typedef struct packed {
      logic [1:0]      orientation;
      logic            gray_mode;
      logic [PX_W-1:0] panel_width;
      logic [PX_W-1:0] panel_height;
   } cfg_type;

   typedef struct packed {
      cmd_type              cmd;
      logic                 oob;
      logic [IDX_W-1:0]     idx;
      logic [SHIFT_W-1:0]   shift;
      logic                 gray;
      logic [COLOR_W-1:0]   color;
   } entry_type;

endpackage

// ===== rtl/core/rfb_if.sv =====
// request, response and register write channel interfaces
interface rfb_req_if;
   logic                       valid;
   logic                       ready;
   logic [rfb_pkg::CMD_W-1:0]   command;
   logic [rfb_pkg::POS_W-1:0]   pos_x;
   logic [rfb_pkg::POS_W-1:0]   pos_y;
   logic [rfb_pkg::COLOR_W-1:0] color;
   modport source (output valid, command, pos_x, pos_y, color, input ready);
   modport sink (input valid, command, pos_x, pos_y, color, output ready);
endinterface

interface rfb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rfb_pkg::COLOR_W-1:0] read_color;
   modport source (output valid, read_color, input ready);
   modport sink (input valid, read_color, output ready);
endinterface

interface rfb_csr_if;
   logic                            valid;
   logic                            ready;
   logic [rfb_pkg::CSR_INDEX_W-1:0] index;
   logic [rfb_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rfb_ram.sv =====
// generic single write, single read ram with registered read data
module rfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rfb_queue.sv =====
// short request queue between front and back
module rfb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               enq_valid,
   output logic               enq_ready,
   input  rfb_pkg::entry_type enq_data,
   output logic               deq_valid,
   input  logic               deq_ready,
   output rfb_pkg::entry_type deq_data
);

   rfb_pkg::entry_type              slot_ff [rfb_pkg::QUEUE_DEPTH];
   logic [rfb_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [rfb_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rfb_pkg::QPTR_W:0]         count_ff, count_in;
   logic                            push, pop;

   always_comb begin
      enq_ready = count_ff != (rfb_pkg::QPTR_W + 1)'(rfb_pkg::QUEUE_DEPTH);
      deq_valid = count_ff != '0;
      deq_data  = slot_ff[rd_ptr_ff];
      push      = enq_valid && enq_ready;
      pop       = deq_valid && deq_ready;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= enq_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/rfb_front.sv =====
// request intake: bounds check, rotation and byte address computation
module rfb_front #(
   parameter int BUFFER_BYTES = 131072
) (
   input  logic               clock,
   input  logic               reset,
   rfb_req_if.sink            req_bus,
   input  rfb_pkg::cfg_type   cfg,
   input  logic               hold,
   output logic               enq_valid,
   input  logic               enq_ready,
   output rfb_pkg::entry_type enq_data
);

   localparam logic [rfb_pkg::IDX_W:0] LIMIT = (rfb_pkg::IDX_W + 1)'(BUFFER_BYTES);

   // stage one: classified request
   logic                            s1_valid_ff, s1_valid_in;
   logic [rfb_pkg::CMD_W-1:0]        s1_cmd_ff;
   logic                            s1_inb_ff, s1_inb_in;
   logic [rfb_pkg::PX_W-1:0]         s1_px_ff, s1_px_in;
   logic [rfb_pkg::PX_W-1:0]         s1_py_ff, s1_py_in;
   logic [rfb_pkg::ROW_W-1:0]        s1_row_ff, s1_row_in;
   logic                            s1_gray_ff;
   logic [rfb_pkg::COLOR_W-1:0]      s1_color_ff;

   // stage two: row offset product
   logic                            s2_valid_ff;
   logic [rfb_pkg::CMD_W-1:0]        s2_cmd_ff;
   logic                            s2_inb_ff;
   logic [rfb_pkg::PROD_W-1:0]       s2_prod_ff, s2_prod_in;
   logic [rfb_pkg::COL_W-1:0]        s2_col_ff, s2_col_in;
   logic [rfb_pkg::SHIFT_W-1:0]      s2_shift_ff, s2_shift_in;
   logic                            s2_gray_ff;
   logic [rfb_pkg::COLOR_W-1:0]      s2_color_ff;

   logic                            swap;
   logic [rfb_pkg::PX_W-1:0]         eff_w, eff_h, x_ext, y_ext;
   logic [rfb_pkg::IDX_W-1:0]        idx;
   logic                            fits, keep, advance;

   always_comb begin
      swap  = cfg.orientation == rfb_pkg::ROT_90 || cfg.orientation == rfb_pkg::ROT_270;
      eff_w = swap ? cfg.panel_height : cfg.panel_width;
      eff_h = swap ? cfg.panel_width : cfg.panel_height;
      x_ext = rfb_pkg::PX_W'(req_bus.pos_x);
      y_ext = rfb_pkg::PX_W'(req_bus.pos_y);
      s1_inb_in = (x_ext < eff_w) && (y_ext < eff_h);
      unique case (cfg.orientation)
         rfb_pkg::ROT_90: begin
            s1_px_in = cfg.panel_width - 1'b1 - y_ext;
            s1_py_in = x_ext;
         end
         rfb_pkg::ROT_180: begin
            s1_px_in = cfg.panel_width - 1'b1 - x_ext;
            s1_py_in = cfg.panel_height - 1'b1 - y_ext;
         end
         rfb_pkg::ROT_270: begin
            s1_px_in = y_ext;
            s1_py_in = cfg.panel_height - 1'b1 - x_ext;
         end
         default: begin
            s1_px_in = x_ext;
            s1_py_in = y_ext;
         end
      endcase
      if (cfg.gray_mode) begin
         s1_row_in = rfb_pkg::ROW_W'(((rfb_pkg::PX_W + 1)'(cfg.panel_width) + 12'd3) >> 2);
      end else begin
         s1_row_in = rfb_pkg::ROW_W'(((rfb_pkg::PX_W + 1)'(cfg.panel_width) + 12'd7) >> 3);
      end

      s2_prod_in = rfb_pkg::PROD_W'(rfb_pkg::PROD_W'(s1_py_ff) * rfb_pkg::PROD_W'(s1_row_ff));
      if (s1_gray_ff) begin
         s2_col_in   = rfb_pkg::COL_W'(s1_px_ff >> 2);
         s2_shift_in = {~s1_px_ff[1:0], 1'b0};
      end else begin
         s2_col_in   = rfb_pkg::COL_W'(s1_px_ff >> 3);
         s2_shift_in = ~s1_px_ff[2:0];
      end

      idx  = rfb_pkg::IDX_W'(s2_prod_ff) + rfb_pkg::IDX_W'(s2_col_ff);
      fits = {1'b0, idx} < LIMIT;
      unique case (s2_cmd_ff)
         rfb_pkg::CMD_WRITE: keep = s2_inb_ff && fits;
         rfb_pkg::CMD_READ:  keep = 1'b1;
         rfb_pkg::CMD_CLEAR: keep = 1'b1;
         default:            keep = 1'b0;
      endcase

      enq_valid      = s2_valid_ff && keep;
      enq_data.cmd   = rfb_pkg::cmd_type'(s2_cmd_ff);
      enq_data.oob   = !(s2_inb_ff && fits);
      enq_data.idx   = idx;
      enq_data.shift = s2_shift_ff;
      enq_data.gray  = s2_gray_ff;
      enq_data.color = s2_color_ff;

      advance       = !s2_valid_ff || !keep || enq_ready;
      req_bus.ready = advance && !hold;
      s1_valid_in   = req_bus.valid && !hold;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff   <= req_bus.command;
         s1_inb_ff   <= s1_inb_in;
         s1_px_ff    <= s1_px_in;
         s1_py_ff    <= s1_py_in;
         s1_row_ff   <= s1_row_in;
         s1_gray_ff  <= cfg.gray_mode;
         s1_color_ff <= req_bus.color;
         s2_cmd_ff   <= s1_cmd_ff;
         s2_inb_ff   <= s1_inb_ff;
         s2_prod_ff  <= s2_prod_in;
         s2_col_ff   <= s2_col_in;
         s2_shift_ff <= s2_shift_in;
         s2_gray_ff  <= s1_gray_ff;
         s2_color_ff <= s1_color_ff;
      end
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

endmodule

// ===== rtl/core/rfb_back.sv =====
// store side: byte read-modify-write, pixel read, clear sweep and response register
module rfb_back #(
   parameter int BUFFER_BYTES = 131072
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               deq_valid,
   output logic               deq_ready,
   input  rfb_pkg::entry_type deq_data,
   output logic               init_busy,
   rfb_rsp_if.source          rsp_bus
);

   localparam int ADDR_W = BUFFER_BYTES > 1 ? $clog2(BUFFER_BYTES) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BUFFER_BYTES - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_MODIFY,
      S_CLEAR
   } state_type;

   state_type                    state_ff, state_in;
   rfb_pkg::entry_type           cur_ff, cur_in;
   logic [ADDR_W-1:0]            ptr_ff, ptr_in;
   logic [7:0]                   fill_ff, fill_in;
   logic                         init_ff, init_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rfb_pkg::COLOR_W-1:0]  rsp_color_ff, rsp_color_in;

   logic                         pop;
   logic                         ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]            ram_wr_addr;
   logic [7:0]                   ram_wr_data, ram_rd_data;
   logic [7:0]                   gmask, bmask, shifted, merged;
   logic [rfb_pkg::COLOR_W-1:0]  code;
   logic                         slot_free;

   rfb_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (deq_data.idx[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      deq_ready = state_ff == S_IDLE;
      pop       = deq_valid && deq_ready;
      ram_rd_en = pop && (deq_data.cmd == rfb_pkg::CMD_READ
                          || deq_data.cmd == rfb_pkg::CMD_WRITE);

      gmask   = 8'(2'b11) << cur_ff.shift;
      bmask   = 8'(1'b1) << cur_ff.shift;
      shifted = ram_rd_data >> cur_ff.shift;
      if (cur_ff.gray) begin
         merged = (ram_rd_data & ~gmask) | (8'(cur_ff.color) << cur_ff.shift);
         code   = shifted[1:0];
      end else begin
         merged = (cur_ff.color == rfb_pkg::COLOR_WHITE) ? (ram_rd_data | bmask)
                                                         : (ram_rd_data & ~bmask);
         code   = shifted[0] ? rfb_pkg::COLOR_WHITE : 2'd0;
      end
      if (cur_ff.oob) begin
         code = rfb_pkg::COLOR_WHITE;
      end

      if (deq_data.gray) begin
         fill_in = {4{deq_data.color}};
      end else begin
         fill_in = (deq_data.color == rfb_pkg::COLOR_WHITE) ? rfb_pkg::BYTE_WHITE
                                                            : rfb_pkg::BYTE_BLACK;
      end

      slot_free    = !rsp_valid_ff || rsp_bus.ready;
      state_in     = state_ff;
      cur_in       = pop ? deq_data : cur_ff;
      ptr_in       = ptr_ff;
      init_in      = init_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_color_in = rsp_color_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cur_ff.idx[ADDR_W-1:0];
      ram_wr_data  = merged;

      unique case (state_ff)
         S_IDLE: begin
            if (pop) begin
               unique case (deq_data.cmd)
                  rfb_pkg::CMD_READ:  state_in = S_READ;
                  rfb_pkg::CMD_WRITE: state_in = S_MODIFY;
                  default: begin
                     state_in = S_CLEAR;
                     ptr_in   = '0;
                  end
               endcase
            end
         end
         S_READ: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = code;
               state_in     = S_IDLE;
            end
         end
         S_MODIFY: begin
            ram_wr_en = 1'b1;
            state_in  = S_IDLE;
         end
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff;
            ram_wr_data = fill_ff;
            ptr_in      = ptr_ff + 1'b1;
            if (ptr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
               init_in  = 1'b0;
            end
         end
         default: state_in = S_IDLE;
      endcase

      init_busy          = init_ff;
      rsp_bus.valid      = rsp_valid_ff;
      rsp_bus.read_color = rsp_color_ff;
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      rsp_color_ff <= rsp_color_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         fill_ff      <= rfb_pkg::BYTE_WHITE;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         if (pop) begin
            fill_ff <= fill_in;
         end
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/rotated_packed_framebuffer_unit.sv =====
// top level of the rotated packed frame buffer
//
// channel   dir   payload                          handshake
// req_bus   in    command, pos_x, pos_y, color     valid / ready
// rsp_bus   out   read_color                       valid / ready
// csr_bus   in    index, data                      valid / ready, always ready
//
// front: two-stage pipeline, one request a cycle unless queue full, then a four-entry queue
// a pixel write is a byte read then write on the single store ram
// a pixel read is a registered ram read into the response register; out of bounds reads return white
// a clear enters the sweep state, then writes one byte a cycle over all BUFFER_BYTES bytes
// after reset a white fill pass over all BUFFER_BYTES bytes runs before any request is taken
// a stalled response holds the back only at a read; writes and clears do not wait on it themselves
module rotated_packed_framebuffer_unit #(
   parameter int BUFFER_BYTES = 131072
) (
   input  logic     clock,
   input  logic     reset,
   rfb_req_if.sink  req_bus,
   rfb_rsp_if.source rsp_bus,
   rfb_csr_if.sink  csr_bus
);

   rfb_pkg::cfg_type   cfg_ff, cfg_in;
   rfb_pkg::entry_type enq_data, deq_data;
   logic               enq_valid, enq_ready, deq_valid, deq_ready;
   logic               init_busy;

   always_comb begin
      csr_bus.ready = 1'b1;
      cfg_in        = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            rfb_pkg::CSR_ORIENTATION: cfg_in.orientation  = csr_bus.data[1:0];
            rfb_pkg::CSR_GRAY_MODE:   cfg_in.gray_mode    = csr_bus.data[0];
            rfb_pkg::CSR_WIDTH:       cfg_in.panel_width  = csr_bus.data;
            rfb_pkg::CSR_HEIGHT:      cfg_in.panel_height = csr_bus.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.orientation  <= rfb_pkg::ROT_0;
         cfg_ff.gray_mode    <= 1'b0;
         cfg_ff.panel_width  <= rfb_pkg::RESET_WIDTH;
         cfg_ff.panel_height <= rfb_pkg::RESET_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rfb_front #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cfg       (cfg_ff),
      .hold      (init_busy),
      .enq_valid (enq_valid),
      .enq_ready (enq_ready),
      .enq_data  (enq_data)
   );

   rfb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq_valid (enq_valid),
      .enq_ready (enq_ready),
      .enq_data  (enq_data),
      .deq_valid (deq_valid),
      .deq_ready (deq_ready),
      .deq_data  (deq_data)
   );

   rfb_back #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .deq_valid (deq_valid),
      .deq_ready (deq_ready),
      .deq_data  (deq_data),
      .init_busy (init_busy),
      .rsp_bus   (rsp_bus)
   );

endmodule
